// ----- src/udp_port_filter_rx_queue_macros.svh -----
// Assertion macros shared by the UDP port filter receive queue modules.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef UDP_PORT_FILTER_RX_QUEUE_MACROS_SVH
`define UDP_PORT_FILTER_RX_QUEUE_MACROS_SVH

// same-cycle implication
`define UDPQ_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UDPQ_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/udpq_pkg.sv -----
// Shared types, constants and helpers for the UDP port filter receive queue.
// No dependencies; imported by every module of the block but udpq_ram.
package udpq_pkg;

	localparam int unsigned SLOT_COUNT = 4;
	localparam int unsigned SLOT_BYTES = 512;
	localparam int unsigned BEAT_BYTES = 8;
	localparam int unsigned UDP_HDR_BYTES = 8;

	localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
	localparam int unsigned WORDS_PER_SLOT = (SLOT_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
	localparam int unsigned PAY_DEPTH = SLOT_COUNT * WORDS_PER_SLOT;
	localparam int unsigned PAY_AW = $clog2(PAY_DEPTH);

	localparam int unsigned CNT_W = 16;
	localparam int unsigned PORT_W = 16;
	localparam int unsigned IP_W = 32;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned LEN_W = 10;
	localparam int unsigned BC_W = 4;
	localparam int unsigned HLEN_W = 6;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned LANES = DATA_W / 8;

	// metadata word: [63:32] source ip, [31:16] source port, [15:0] stored length
	localparam logic [LANES-1:0] META_BE_IP = 8'hF0;
	localparam logic [LANES-1:0] META_BE_PORT_HI = 8'h08;
	localparam logic [LANES-1:0] META_BE_PORT_LO = 8'h04;
	localparam logic [LANES-1:0] META_BE_LEN = 8'h03;

	typedef enum logic [1:0] {
		STAT_ERROR = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_DATA  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOUND_PORT = 1'b0,
		REG_RX_ENABLE  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RD_IDLE,
		RD_META,
		RD_BEAT
	} rd_state_t;

	typedef struct packed {
		logic [PORT_W-1:0] bound_port;
		logic              rx_enable;
		logic              clear;
	} cfg_t;

	typedef struct packed {
		logic [LANES-1:0]  be;
		logic [PAY_AW-1:0] addr;
		logic [DATA_W-1:0] data;
	} pay_wr_t;

	typedef struct packed {
		logic [LANES-1:0]  be;
		logic [SLOT_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} meta_wr_t;

	typedef struct packed {
		status_t           status;
		logic [IP_W-1:0]   sender_ip;
		logic [PORT_W-1:0] sender_port;
		logic [DATA_W-1:0] data_word;
		logic [BC_W-1:0]   byte_count;
		logic              beat_last;
		logic [LEN_W-1:0]  delivered_len;
	} result_t;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] n;
		if (s == SLOT_W'(SLOT_COUNT - 1)) begin
			n = '0;
		end else begin
			n = s + 1'b1;
		end
		return n;
	endfunction

	// keep the first cnt bytes, counted from the most significant end
	function automatic logic [DATA_W-1:0] byte_keep_mask(input logic [BC_W-1:0] cnt);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int i = 0; i < LANES; i++) begin
			if (BC_W'(i) < cnt) begin
				m[DATA_W-1-8*i -: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

// ----- src/udpq_ram.sv -----
// Simple dual-port RAM with byte-lane write enables and registered read data.
// Generic; no package dependency.
module udpq_ram #(
	parameter int unsigned DEPTH = 4,
	parameter int unsigned NUM_LANES = 8,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic [NUM_LANES-1:0]   we,
	input  logic [AW-1:0]          waddr,
	input  logic [8*NUM_LANES-1:0] wdata,
	input  logic [AW-1:0]          raddr,
	output logic [8*NUM_LANES-1:0] rdata
);

	logic [8*NUM_LANES-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_LANES; i++) begin
			if (we[i]) begin
				mem[waddr][8*i +: 8] <= wdata[8*i +: 8];
			end
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/udpq_ingress.sv -----
// Ingress byte parser: tracks packet offset, picks out addresses and ports,
// writes payload and slot metadata, and commits packets to the ring. Uses udpq_pkg.
`include "udp_port_filter_rx_queue_macros.svh"

module udpq_ingress (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [7:0]                   in_byte,
	input  logic                         in_last,
	input  logic [udpq_pkg::HLEN_W-1:0]  header_len,
	input  udpq_pkg::cfg_t               cfg,
	input  logic [udpq_pkg::SLOT_W-1:0]  read_slot,
	output logic [udpq_pkg::SLOT_W-1:0]  write_slot,
	output udpq_pkg::pay_wr_t            pay_wr,
	output udpq_pkg::meta_wr_t           meta_wr
);
	import udpq_pkg::*;

	logic [CNT_W-1:0]  offset_q;
	logic [PORT_W-1:0] dst_port_q;
	logic [SLOT_W-1:0] write_slot_q;

	logic [CNT_W:0]   off_x, len_x, hdr_x, pay_start, pay_pos, pay_len;
	logic             in_payload, commit, is_ip_byte;
	logic [LEN_W-1:0] store_len;

	always_comb begin
		off_x     = {1'b0, offset_q};
		hdr_x     = (CNT_W+1)'(header_len);
		len_x     = off_x + 1'b1;
		pay_start = hdr_x + (CNT_W+1)'(UDP_HDR_BYTES);
		pay_pos   = off_x - pay_start;
		pay_len   = len_x - pay_start;
		if (pay_len > (CNT_W+1)'(SLOT_BYTES)) begin
			store_len = LEN_W'(SLOT_BYTES);
		end else begin
			store_len = LEN_W'(pay_len);
		end
		in_payload = (off_x >= pay_start) && (pay_pos < (CNT_W+1)'(SLOT_BYTES));
		// source address sits at offsets 12..15
		is_ip_byte = (offset_q[CNT_W-1:2] == (CNT_W-2)'(3));
		commit = accept && in_last && cfg.rx_enable && (len_x >= pay_start)
			&& (dst_port_q == cfg.bound_port) && (next_slot(write_slot_q) != read_slot);
	end

	always_comb begin
		pay_wr.be   = '0;
		pay_wr.addr = PAY_AW'(32'(write_slot_q) * WORDS_PER_SLOT + 32'(pay_pos >> 3));
		pay_wr.data = {LANES{in_byte}};
		if (accept && in_payload) begin
			pay_wr.be = 8'h80 >> pay_pos[2:0];
		end
	end

	always_comb begin
		meta_wr.be   = '0;
		meta_wr.addr = write_slot_q;
		meta_wr.data = {(offset_q == '0) ? 32'h0 : {4{in_byte}}, {2{in_byte}}, 16'(store_len)};
		if (accept) begin
			if (offset_q == '0) begin
				meta_wr.be = meta_wr.be | META_BE_IP;
			end
			if (is_ip_byte) begin
				meta_wr.be = meta_wr.be | (8'h80 >> offset_q[1:0]);
			end
			if (off_x == hdr_x) begin
				meta_wr.be = meta_wr.be | META_BE_PORT_HI;
			end
			if (off_x == hdr_x + 1'b1) begin
				meta_wr.be = meta_wr.be | META_BE_PORT_LO;
			end
		end
		if (commit) begin
			meta_wr.be = meta_wr.be | META_BE_LEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= '0;
			dst_port_q   <= '0;
			write_slot_q <= '0;
		end else begin
			if (accept) begin
				if (in_last) begin
					offset_q   <= '0;
					dst_port_q <= '0;
				end else begin
					if (offset_q != '1) begin
						offset_q <= offset_q + 1'b1;
					end
					if (off_x == hdr_x + 2'd2) begin
						dst_port_q[15:8] <= in_byte;
					end else if (off_x == hdr_x + 2'd3) begin
						dst_port_q[7:0] <= in_byte;
					end
				end
			end
			if (cfg.clear) begin
				write_slot_q <= '0;
			end else if (commit) begin
				write_slot_q <= next_slot(write_slot_q);
			end
		end
	end

	assign write_slot = write_slot_q;

	`UDPQ_ASSERT_NXT(a_commit_keeps_gap, commit && !cfg.clear, write_slot_q != read_slot, "ring overfilled")
	`UDPQ_ASSERT_NXT(a_offset_saturates, accept && !in_last && offset_q == '1, offset_q == '1, "offset wrapped")

endmodule

// ----- src/udpq_reader.sv -----
// Receive request sequencer: reads slot metadata, streams payload words as
// beats and frees the slot; also answers error and empty requests. Uses udpq_pkg.
`include "udp_port_filter_rx_queue_macros.svh"

module udpq_reader (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [udpq_pkg::LEN_W-1:0]   read_cap,
	input  udpq_pkg::cfg_t               cfg,
	input  logic [udpq_pkg::SLOT_W-1:0]  write_slot,
	output logic [udpq_pkg::SLOT_W-1:0]  read_slot,
	output logic                         busy,
	input  logic [udpq_pkg::DATA_W-1:0]  meta_rdata,
	output logic [udpq_pkg::PAY_AW-1:0]  pay_raddr,
	input  logic [udpq_pkg::DATA_W-1:0]  pay_rdata,
	output logic                         res_strobe,
	output udpq_pkg::result_t            res
);
	import udpq_pkg::*;

	rd_state_t state_q, state_d;
	logic [SLOT_W-1:0] read_slot_q;
	logic [LEN_W-1:0]  cap_q, total_q, pos_q, remain, stored_len, meta_total;
	logic [IP_W-1:0]   ip_q;
	logic [PORT_W-1:0] port_q;
	logic [BC_W-1:0]   beat_cnt, cnt_s1;
	logic              beat_issue, beat_last_c, valid_s1, last_s1;
	logic              rd_error, rd_empty, rd_start;
	logic              res_strobe_q;
	result_t           res_q;

	always_comb begin
		rd_error = accept && (!cfg.rx_enable || read_cap == '0);
		rd_empty = accept && !rd_error && (read_slot_q == write_slot);
		rd_start = accept && !rd_error && !rd_empty;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			RD_IDLE: begin
				if (rd_start) begin
					state_d = RD_META;
				end
			end
			RD_META: begin
				state_d = RD_BEAT;
			end
			RD_BEAT: begin
				if (beat_last_c) begin
					state_d = RD_IDLE;
				end
			end
			default: begin
				state_d = RD_IDLE;
			end
		endcase
	end

	always_comb begin
		stored_len  = meta_rdata[LEN_W-1:0];
		meta_total  = (stored_len > cap_q) ? cap_q : stored_len;
		remain      = total_q - pos_q;
		beat_last_c = (remain <= LEN_W'(BEAT_BYTES));
		beat_cnt    = beat_last_c ? BC_W'(remain) : BC_W'(BEAT_BYTES);
		beat_issue  = (state_q == RD_BEAT);
		pay_raddr   = PAY_AW'(32'(read_slot_q) * WORDS_PER_SLOT + 32'(pos_q >> 3));
		busy        = (state_q != RD_IDLE) || valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= RD_IDLE;
			read_slot_q  <= '0;
			valid_s1     <= 1'b0;
			res_strobe_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			valid_s1     <= beat_issue;
			res_strobe_q <= valid_s1 || rd_error || rd_empty;
			if (cfg.clear) begin
				read_slot_q <= '0;
			end else if (beat_issue && beat_last_c) begin
				read_slot_q <= next_slot(read_slot_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_start) begin
			cap_q <= read_cap;
		end
		if (state_q == RD_META) begin
			total_q <= meta_total;
			pos_q   <= '0;
			ip_q    <= meta_rdata[63:32];
			port_q  <= meta_rdata[31:16];
		end else if (beat_issue) begin
			pos_q <= pos_q + LEN_W'(beat_cnt);
		end
		if (beat_issue) begin
			cnt_s1  <= beat_cnt;
			last_s1 <= beat_last_c;
		end
		if (valid_s1) begin
			res_q.status        <= STAT_DATA;
			res_q.sender_ip     <= ip_q;
			res_q.sender_port   <= port_q;
			res_q.data_word     <= pay_rdata & byte_keep_mask(cnt_s1);
			res_q.byte_count    <= cnt_s1;
			res_q.beat_last     <= last_s1;
			res_q.delivered_len <= total_q;
		end else if (rd_error || rd_empty) begin
			res_q.status        <= rd_error ? STAT_ERROR : STAT_EMPTY;
			res_q.sender_ip     <= '0;
			res_q.sender_port   <= '0;
			res_q.data_word     <= '0;
			res_q.byte_count    <= '0;
			res_q.beat_last     <= 1'b1;
			res_q.delivered_len <= '0;
		end
	end

	assign read_slot  = read_slot_q;
	assign res_strobe = res_strobe_q;
	assign res        = res_q;

	`UDPQ_ASSERT_NXT(a_meta_then_beat, state_q == RD_META, state_q == RD_BEAT, "metadata not followed by beats")
	`UDPQ_ASSERT_NXT(a_beat_delivered, valid_s1, res_strobe_q && res_q.status == STAT_DATA, "issued beat lost")
	`UDPQ_ASSERT_IMP(a_short_beat_last, res_strobe_q && res_q.status == STAT_DATA && res_q.byte_count != 4'd8, res_q.beat_last, "partial beat not last")

endmodule

// ----- src/udp_port_filter_rx_queue.sv -----
// Top level of the UDP port filter receive queue: configuration registers,
// payload and metadata RAMs, ingress parser and receive sequencer. Uses udpq_pkg.
//
//  channel  | handshake              | fields
//  ---------+------------------------+---------------------------------------------
//  item in  | start & !busy          | req_type in_byte in_last header_len read_cap
//  config   | cfg_we                 | cfg_index cfg_data
//  result   | result_strobe (1 cyc)  | status sender_ip sender_port data_word
//           |                        | byte_count beat_last delivered_len
//
// Ingress bytes may arrive back to back while busy is low.
// An error or empty request gives its result the cycle after it is taken.
// During a receive, busy stays high through a metadata RAM read, one payload RAM
// read per beat, and the last word's read cycle; beats are consecutive.
// Reset clears the slot pointers and configuration registers; RAM contents are not cleared.
// Results are never held off; the receiver must take each one as it appears.
module udp_port_filter_rx_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic [7:0]                      in_byte,
	input  logic                            in_last,
	input  logic [udpq_pkg::HLEN_W-1:0]     header_len,
	input  logic [udpq_pkg::LEN_W-1:0]      read_cap,
	input  logic                            cfg_we,
	input  logic [udpq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [udpq_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            result_strobe,
	output logic [1:0]                      status,
	output logic [udpq_pkg::IP_W-1:0]       sender_ip,
	output logic [udpq_pkg::PORT_W-1:0]     sender_port,
	output logic [udpq_pkg::DATA_W-1:0]     data_word,
	output logic [udpq_pkg::BC_W-1:0]       byte_count,
	output logic                            beat_last,
	output logic [udpq_pkg::LEN_W-1:0]      delivered_len
);
	import udpq_pkg::*;

	logic [PORT_W-1:0] bound_port_q;
	logic              rx_enable_q;
	logic              cfg_hit;
	cfg_t              cfg;
	logic              accept, ing_accept, rd_accept, rd_busy;
	logic [SLOT_W-1:0] write_slot, read_slot;
	pay_wr_t           pay_wr;
	meta_wr_t          meta_wr;
	logic [PAY_AW-1:0] pay_raddr;
	logic [DATA_W-1:0] pay_rdata, meta_rdata;
	result_t           res;

	always_comb begin
		case (cfg_reg_t'(cfg_index))
			REG_BOUND_PORT, REG_RX_ENABLE: cfg_hit = cfg_we;
			default:                       cfg_hit = 1'b0;
		endcase
		cfg.bound_port = bound_port_q;
		cfg.rx_enable  = rx_enable_q;
		cfg.clear      = cfg_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_port_q <= '0;
			rx_enable_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BOUND_PORT: bound_port_q <= cfg_data;
				REG_RX_ENABLE:  rx_enable_q  <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	assign busy       = rd_busy;
	assign accept     = start && !rd_busy;
	assign ing_accept = accept && !req_type;
	assign rd_accept  = accept && req_type;

	udpq_ingress u_ingress (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (ing_accept),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.header_len (header_len),
		.cfg        (cfg),
		.read_slot  (read_slot),
		.write_slot (write_slot),
		.pay_wr     (pay_wr),
		.meta_wr    (meta_wr)
	);

	udpq_ram #(
		.DEPTH     (PAY_DEPTH),
		.NUM_LANES (LANES)
	) u_pay_ram (
		.clk   (clk),
		.we    (pay_wr.be),
		.waddr (pay_wr.addr),
		.wdata (pay_wr.data),
		.raddr (pay_raddr),
		.rdata (pay_rdata)
	);

	udpq_ram #(
		.DEPTH     (SLOT_COUNT),
		.NUM_LANES (LANES)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_wr.be),
		.waddr (meta_wr.addr),
		.wdata (meta_wr.data),
		.raddr (read_slot),
		.rdata (meta_rdata)
	);

	udpq_reader u_reader (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (rd_accept),
		.read_cap   (read_cap),
		.cfg        (cfg),
		.write_slot (write_slot),
		.read_slot  (read_slot),
		.busy       (rd_busy),
		.meta_rdata (meta_rdata),
		.pay_raddr  (pay_raddr),
		.pay_rdata  (pay_rdata),
		.res_strobe (result_strobe),
		.res        (res)
	);

	assign status        = res.status;
	assign sender_ip     = res.sender_ip;
	assign sender_port   = res.sender_port;
	assign data_word     = res.data_word;
	assign byte_count    = res.byte_count;
	assign beat_last     = res.beat_last;
	assign delivered_len = res.delivered_len;

endmodule

// ----- tb/udpq_rx_checker.sv -----
// Request codes shared by the testbench files, and the result checker for
// udp_port_filter_rx_queue. Depends on udpq_pkg for widths, status codes and
// register indexes.
package udpq_tb_pkg;

	localparam bit REQ_INGRESS = 1'b0;
	localparam bit REQ_RECEIVE = 1'b1;

endpackage

// Mirrors the ingress parser and the slot ring, predicts every result beat of
// an accepted item and compares it with what the block puts out.
module udpq_rx_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic                            req_type,
	input  logic [7:0]                      in_byte,
	input  logic                            in_last,
	input  logic [udpq_pkg::HLEN_W-1:0]     header_len,
	input  logic [udpq_pkg::LEN_W-1:0]      read_cap,
	input  logic                            cfg_we,
	input  logic [udpq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [udpq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            result_strobe,
	input  logic [1:0]                      status,
	input  logic [udpq_pkg::IP_W-1:0]       sender_ip,
	input  logic [udpq_pkg::PORT_W-1:0]     sender_port,
	input  logic [udpq_pkg::DATA_W-1:0]     data_word,
	input  logic [udpq_pkg::BC_W-1:0]       byte_count,
	input  logic                            beat_last,
	input  logic [udpq_pkg::LEN_W-1:0]      delivered_len,
	output int                              mismatches,
	output int                              beats_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import udpq_pkg::*;
	import udpq_tb_pkg::*;

	bit [7:0]          slot_bytes [SLOT_COUNT][SLOT_BYTES];
	bit [IP_W-1:0]     slot_ip [SLOT_COUNT];
	bit [PORT_W-1:0]   slot_port [SLOT_COUNT];
	bit [LEN_W-1:0]    slot_len [SLOT_COUNT];
	bit [SLOT_W-1:0]   fill_slot;
	bit [SLOT_W-1:0]   drain_slot;
	int unsigned       rx_offset;
	bit [PORT_W-1:0]   dst_port_seen;
	bit [PORT_W-1:0]   cur_bound_port;
	bit                cur_rx_enable;
	result_t           beats_due [$];
	result_t           want;

	function automatic bit [SLOT_W-1:0] slot_after(bit [SLOT_W-1:0] s);
		return SLOT_W'((int'(s) + 1) % SLOT_COUNT);
	endfunction

	function automatic void take_ingress_byte(bit [7:0] b, bit last, int unsigned h);
		int unsigned     o;
		int unsigned     len;
		int unsigned     n;
		bit [SLOT_W-1:0] ws;
		o = rx_offset;
		ws = fill_slot;
		// address is rebuilt per packet; bytes that never come stay zero
		if (o == 0) begin
			slot_ip[ws] = '0;
		end
		if (o >= 12 && o <= 15) begin
			slot_ip[ws][8*(15-o) +: 8] = b;
		end
		if (o == h) begin
			slot_port[ws][15:8] = b;
		end else if (o == h + 1) begin
			slot_port[ws][7:0] = b;
		end else if (o == h + 2) begin
			dst_port_seen[15:8] = b;
		end else if (o == h + 3) begin
			dst_port_seen[7:0] = b;
		end
		if (o >= h + UDP_HDR_BYTES && o - h - UDP_HDR_BYTES < SLOT_BYTES) begin
			slot_bytes[ws][o - h - UDP_HDR_BYTES] = b;
		end
		if (last) begin
			len = o + 1;
			if (cur_rx_enable && len >= h + UDP_HDR_BYTES && dst_port_seen == cur_bound_port &&
					slot_after(ws) != drain_slot) begin
				n = len - h - UDP_HDR_BYTES;
				if (n > SLOT_BYTES) begin
					n = SLOT_BYTES;
				end
				slot_len[ws] = LEN_W'(n);
				fill_slot = slot_after(ws);
			end
			rx_offset = 0;
			dst_port_seen = '0;
		end else if (rx_offset < 16'hFFFF) begin
			rx_offset++;
		end
	endfunction

	function automatic void serve_receive(int unsigned cap);
		result_t         r;
		int unsigned     n;
		int unsigned     pos;
		int unsigned     cnt;
		bit [SLOT_W-1:0] rs;
		r = '0;
		r.beat_last = 1'b1;
		if (!cur_rx_enable || cap == 0) begin
			r.status = STAT_ERROR;
			beats_due.push_back(r);
		end else if (drain_slot == fill_slot) begin
			r.status = STAT_EMPTY;
			beats_due.push_back(r);
		end else begin
			rs = drain_slot;
			n = 32'(slot_len[rs]);
			if (n > cap) begin
				n = cap;
			end
			pos = 0;
			// an empty payload still gives one beat
			do begin
				cnt = (n - pos > BEAT_BYTES) ? BEAT_BYTES : n - pos;
				r = '0;
				r.status = STAT_DATA;
				r.sender_ip = slot_ip[rs];
				r.sender_port = slot_port[rs];
				for (int i = 0; i < int'(cnt); i++) begin
					r.data_word[DATA_W-1-8*i -: 8] = slot_bytes[rs][pos + i];
				end
				pos += cnt;
				r.byte_count = BC_W'(cnt);
				r.beat_last = (pos >= n);
				r.delivered_len = LEN_W'(n);
				beats_due.push_back(r);
			end while (pos < n);
			drain_slot = slot_after(rs);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_slot = '0;
			drain_slot = '0;
			rx_offset = 0;
			dst_port_seen = '0;
			cur_bound_port = '0;
			cur_rx_enable = 1'b0;
			beats_due.delete();
			mismatches = 0;
			beats_pending = 0;
		end else begin
			// results on this edge belong to items taken earlier
			if (result_strobe) begin
				if (beats_due.size() == 0) begin
					$error("unexpected result: status %0d data_word %h", status, data_word);
					mismatches++;
				end else begin
					want = beats_due.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (sender_ip !== want.sender_ip) begin
						$error("sender_ip: expected %h, got %h", want.sender_ip, sender_ip);
						mismatches++;
					end
					if (sender_port !== want.sender_port) begin
						$error("sender_port: expected %h, got %h", want.sender_port, sender_port);
						mismatches++;
					end
					if (data_word !== want.data_word) begin
						$error("data_word: expected %h, got %h", want.data_word, data_word);
						mismatches++;
					end
					if (byte_count !== want.byte_count) begin
						$error("byte_count: expected %0d, got %0d", want.byte_count, byte_count);
						mismatches++;
					end
					if (beat_last !== want.beat_last) begin
						$error("beat_last: expected %0d, got %0d", want.beat_last, beat_last);
						mismatches++;
					end
					if (delivered_len !== want.delivered_len) begin
						$error("delivered_len: expected %0d, got %0d", want.delivered_len,
							delivered_len);
						mismatches++;
					end
				end
			end
			// a register write empties the ring
			if (cfg_we) begin
				if (cfg_index == REG_BOUND_PORT) begin
					cur_bound_port = cfg_data[PORT_W-1:0];
				end else begin
					cur_rx_enable = cfg_data[0];
				end
				fill_slot = '0;
				drain_slot = '0;
			end
			if (start && !busy) begin
				if (req_type == REQ_RECEIVE) begin
					serve_receive(32'(read_cap));
				end else begin
					take_ingress_byte(in_byte, in_last, 32'(header_len));
				end
			end
			beats_pending = beats_due.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for udp_port_filter_rx_queue: clock, reset, directed and random
// ingress packets, receive requests and register writes, and the verdict.
// Depends on udpq_pkg, udpq_tb_pkg and udpq_rx_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import udpq_pkg::*;
	import udpq_tb_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_ITEMS = 360;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 16;
	localparam int IDLE_LIMIT = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  req_type;
	logic [7:0]            in_byte;
	logic                  in_last;
	logic [HLEN_W-1:0]     header_len;
	logic [LEN_W-1:0]      read_cap;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  result_strobe;
	logic [1:0]            status;
	logic [IP_W-1:0]       sender_ip;
	logic [PORT_W-1:0]     sender_port;
	logic [DATA_W-1:0]     data_word;
	logic [BC_W-1:0]       byte_count;
	logic                  beat_last;
	logic [LEN_W-1:0]      delivered_len;
	int                    mismatches;
	int                    beats_pending;

	int                    items_sent = 0;
	int                    quiet_cycles = 0;
	bit                    no_gaps;
	bit                    mix_reads;
	bit [PORT_W-1:0]       bound_now;
	bit [IP_W-1:0]         pkt_ip;
	bit [PORT_W-1:0]       pkt_sport;
	bit [PORT_W-1:0]       pkt_dport;
	int unsigned           pkt_hlen;
	int unsigned           pkt_total;

	always #(CLK_PERIOD / 2) clk = ~clk;

	udp_port_filter_rx_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.header_len    (header_len),
		.read_cap      (read_cap),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.status        (status),
		.sender_ip     (sender_ip),
		.sender_port   (sender_port),
		.data_word     (data_word),
		.byte_count    (byte_count),
		.beat_last     (beat_last),
		.delivered_len (delivered_len)
	);

	udpq_rx_checker rx_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.header_len    (header_len),
		.read_cap      (read_cap),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.status        (status),
		.sender_ip     (sender_ip),
		.sender_port   (sender_port),
		.data_word     (data_word),
		.byte_count    (byte_count),
		.beat_last     (beat_last),
		.delivered_len (delivered_len),
		.mismatches    (mismatches),
		.beats_pending (beats_pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("udp_port_filter_rx_queue: mismatch");
			$finish;
		end
	end

	// mostly back to back, sometimes a short gap, rarely a long pause
	task automatic sender_gap();
		int g;
		int roll;
		roll = $urandom_range(99);
		if (no_gaps || roll < 60) begin
			g = 0;
		end else if (roll < 90) begin
			g = $urandom_range(3, 1);
		end else if (roll < 98) begin
			g = $urandom_range(20, 4);
		end else begin
			g = $urandom_range(150, 30);
		end
		if (g > 0) begin
			@(negedge clk);
			start = 1'b0;
			req_type = 1'($urandom);
			in_byte = 8'($urandom);
			in_last = 1'($urandom);
			header_len = HLEN_W'($urandom);
			read_cap = LEN_W'($urandom);
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic issue(bit rq, bit [7:0] b, bit last, bit [HLEN_W-1:0] h,
			bit [LEN_W-1:0] cap);
		@(negedge clk);
		start = 1'b1;
		req_type = rq;
		in_byte = b;
		in_last = last;
		header_len = h;
		read_cap = cap;
		do begin
			@(posedge clk);
		end while (busy);
		items_sent++;
		sender_gap();
	endtask

	task automatic read_req(bit [LEN_W-1:0] cap);
		issue(REQ_RECEIVE, 8'($urandom), 1'($urandom), HLEN_W'($urandom), cap);
	endtask

	function automatic bit [LEN_W-1:0] pick_cap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10) begin
			return '0;
		end else if (roll < 30) begin
			return LEN_W'($urandom_range(8, 1));
		end else if (roll < 70) begin
			return LEN_W'($urandom_range(64, 9));
		end else if (roll < 90) begin
			return LEN_W'($urandom_range(1023, 512));
		end
		return LEN_W'($urandom);
	endfunction

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (beats_pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] val);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		while (busy) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == REG_BOUND_PORT) begin
			bound_now = val;
		end
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_index = CFG_IDX_W'($urandom);
		cfg_data = CFG_DATA_W'($urandom);
	endtask

	function automatic void shape_packet(int unsigned h, int unsigned total,
			bit [PORT_W-1:0] dport);
		pkt_ip = $urandom;
		pkt_sport = PORT_W'($urandom);
		pkt_dport = dport;
		pkt_hlen = h;
		pkt_total = total;
	endfunction

	// bytes from..upto-1 of the shaped packet; the UDP ports override the
	// address bytes where a short header makes them overlap
	task automatic send_bytes(int unsigned from, int unsigned upto);
		bit [7:0] b;
		for (int unsigned i = from; i < upto; i++) begin
			b = 8'($urandom);
			if (i >= 12 && i <= 15) begin
				b = pkt_ip[8*(15-i) +: 8];
			end
			if (i == pkt_hlen) begin
				b = pkt_sport[15:8];
			end else if (i == pkt_hlen + 1) begin
				b = pkt_sport[7:0];
			end else if (i == pkt_hlen + 2) begin
				b = pkt_dport[15:8];
			end else if (i == pkt_hlen + 3) begin
				b = pkt_dport[7:0];
			end
			if (mix_reads && $urandom_range(99) < 4) begin
				read_req(pick_cap());
			end
			issue(REQ_INGRESS, b, i == pkt_total - 1, HLEN_W'(pkt_hlen), LEN_W'($urandom));
		end
	endtask

	task automatic send_packet(int unsigned h, int unsigned total, bit [PORT_W-1:0] dport);
		shape_packet(h, total, dport);
		send_bytes(0, total);
	endtask

	initial begin
		int unsigned h;
		int unsigned total;
		int          roll;
		int          random_from;
		bit [PORT_W-1:0] dport;

		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_INGRESS;
		in_byte = '0;
		in_last = 1'b0;
		header_len = '0;
		read_cap = '0;
		cfg_we = 1'b0;
		cfg_index = REG_BOUND_PORT;
		cfg_data = '0;
		no_gaps = 1'b0;
		mix_reads = 1'b0;
		bound_now = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// disabled after reset, then zero capacity
		read_req(10'd100);
		read_req('0);
		write_reg(REG_BOUND_PORT, 16'hFFFF);
		write_reg(REG_RX_ENABLE, 16'h0001);
		read_req(10'd8);

		// empty payload, then a capped read and a zero-capacity read in between
		send_packet(20, 28, 16'hFFFF);
		read_req(10'd1023);
		send_packet(20, 41, 16'hFFFF);
		read_req('0);
		read_req(10'd5);

		// too short to hold the UDP header: dropped
		send_packet(20, 25, 16'hFFFF);
		read_req(10'd64);

		// odd header lengths; short packets leave the address partly zero
		send_packet(0, 8, 16'hFFFF);
		send_packet(4, 13, 16'hFFFF);
		send_packet(63, 80, 16'hFFFF);
		read_req(10'd512);
		read_req(10'd512);
		read_req(10'd1023);

		// wrong port dropped; ring holds one packet less than its slots
		write_reg(REG_BOUND_PORT, 16'h0000);
		send_packet(20, 31, 16'h0001);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			send_packet(20, 28 + i, 16'h0000);
		end
		for (int i = 0; i < SLOT_COUNT; i++) begin
			read_req(10'd1023);
		end

		// payload one byte over a slot
		send_packet(20, 20 + 8 + SLOT_BYTES + 1, 16'h0000);
		read_req(10'd512);

		// register writes in the middle of a packet
		shape_packet(20, 32, 16'h5555);
		send_bytes(0, 10);
		write_reg(REG_BOUND_PORT, 16'h5555);
		send_bytes(10, 32);
		read_req(10'd16);
		shape_packet(20, 32, 16'h5555);
		send_bytes(0, 10);
		write_reg(REG_RX_ENABLE, 16'hFFFE);
		send_bytes(10, 32);
		read_req(10'd16);
		write_reg(REG_RX_ENABLE, 16'h0001);
		read_req(10'd16);

		random_from = items_sent;
		while (items_sent - random_from < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 12) begin
				if ($urandom_range(1) == 1) begin
					case ($urandom_range(3))
						0: dport = '0;
						1: dport = '1;
						default: dport = PORT_W'($urandom);
					endcase
					write_reg(REG_BOUND_PORT, dport);
				end else begin
					write_reg(REG_RX_ENABLE, {15'($urandom), ($urandom_range(99) < 85)});
				end
			end
			if ($urandom_range(99) < 10) begin
				no_gaps = ($urandom_range(2) == 0);
				mix_reads = ($urandom_range(3) == 0);
			end
			roll = $urandom_range(99);
			if (roll < 60) begin
				roll = $urandom_range(99);
				if (roll < 80) begin
					h = 20;
				end else if (roll < 90) begin
					h = $urandom_range(60, 21);
				end else begin
					h = $urandom_range(63, 0);
				end
				roll = $urandom_range(99);
				if (roll < 70) begin
					total = h + 8 + $urandom_range(16, 0);
				end else if (roll < 90) begin
					total = h + 8 + $urandom_range(80, 17);
				end else if (roll < 98) begin
					total = h + 8 + $urandom_range(200, 81);
				end else begin
					total = h + 8 + $urandom_range(SLOT_BYTES + 40, SLOT_BYTES - 8);
				end
				if ($urandom_range(99) < 10) begin
					total = $urandom_range(h + 7, 1);
				end
				dport = ($urandom_range(99) < 80) ? bound_now : PORT_W'($urandom);
				send_packet(h, total, dport);
			end else begin
				read_req(pick_cap());
			end
			if ($urandom_range(99) < 5) begin
				drain();
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("udp_port_filter_rx_queue: match");
		end else begin
			$display("udp_port_filter_rx_queue: mismatch");
		end
		$finish;
	end

endmodule
